[design/bf_interpreter_core_unit_defines.svh]
// Assertion helpers for the interpreter core
`ifndef BF_INTERPRETER_CORE_UNIT_DEFINES_SVH
`define BF_INTERPRETER_CORE_UNIT_DEFINES_SVH
// check an implication on every clock edge outside reset
`define BF_ASSERT_IMP(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// check an implication in the cycle after the condition holds
`define BF_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

[design/bf_pkg.sv]
`default_nettype none
package bf_pkg;
   localparam int PROG_DEPTH = 4096;
   localparam int TAPE_DEPTH = 1024;
   localparam int NEST_DEPTH = 64;
   localparam int PA_W = $clog2(PROG_DEPTH);
   localparam int PL_W = PA_W + 1;
   localparam int TA_W = $clog2(TAPE_DEPTH);
   localparam int NA_W = $clog2(NEST_DEPTH);
   localparam int ND_W = NA_W + 1;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STEP  = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_OUT    = 3'd1;
   localparam logic [2:0] ST_WAIT   = 3'd2;
   localparam logic [2:0] ST_HALT   = 3'd3;
   localparam logic [2:0] ST_ERR    = 3'd4;
   localparam logic [2:0] ST_LOADED = 3'd5;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_SYMBOL = 3'd1;
   localparam logic [2:0] ERR_BELOW  = 3'd2;
   localparam logic [2:0] ERR_PAST   = 3'd3;
   localparam logic [2:0] ERR_MATCH  = 3'd4;
   localparam logic [2:0] ERR_FULL   = 3'd5;

   localparam logic [7:0] CH_INC = 8'h2B;
   localparam logic [7:0] CH_DEC = 8'h2D;
   localparam logic [7:0] CH_RT  = 8'h3E;
   localparam logic [7:0] CH_LT  = 8'h3C;
   localparam logic [7:0] CH_OUT = 8'h2E;
   localparam logic [7:0] CH_IN  = 8'h2C;
   localparam logic [7:0] CH_OPN = 8'h5B;
   localparam logic [7:0] CH_CLS = 8'h5D;

   typedef enum logic [1:0] {RUN_IDLE, RUN_GO, RUN_HALT, RUN_ERR} run_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] program_char;
      logic [7:0] input_char;
      logic       input_ready;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_char;
      logic [2:0]  error_code;
      logic [12:0] program_counter;
   } rsp_type;
endpackage
`default_nettype wire

[design/bf_ram.sv]
`default_nettype none
module bf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[design/bf_interpreter_core_unit.sv]
// Interpreter core: one item at a time. Load replies directly, a close bracket via S_LD_POP
// and S_LD_MATCH; start runs the tape clear sweep, one cell a cycle. Step replies directly
// when not running or at end; moves and faults pass S_FETCH, S_DECODE; cell ops add S_CELL,
// a jump S_MATCH, a fold S_FOLD1 to S_FOLD3 (unmatched then S_CELL). The next item is taken
// the cycle after reply. A stalled result beat only holds the following item in S_REPLY.
// Synchronous reset clears control state; memories are defined by writes only.
`default_nettype none
`include "bf_interpreter_core_unit_defines.svh"
module bf_interpreter_core_unit (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_valid,
   output      logic            csr_ready,
   input  wire logic            csr_data,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire bf_pkg::req_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      bf_pkg::rsp_type rsp_data
);
   import bf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LD_POP, S_LD_MATCH, S_CLEAR, S_FETCH, S_DECODE,
      S_CELL, S_FOLD1, S_FOLD2, S_FOLD3, S_MATCH, S_REPLY
   } fsm_type;

   fsm_type       state_ff, state_in;
   req_type       item_ff, item_in;
   rsp_type       res_ff, res_in;
   rsp_type       out_ff, out_in;
   logic          out_valid_ff, out_valid_in;
   logic          fold_ff, fold_in;
   logic [ND_W-1:0] depth_ff, depth_in;
   logic [PL_W-1:0] len_ff, len_in;
   logic [PL_W-1:0] pc_ff, pc_in;
   logic [TA_W-1:0] tp_ff, tp_in;
   logic [TA_W:0]   clr_ff, clr_in;
   run_type       run_ff, run_in;
   logic          bfault_ff, bfault_in;
   logic [2:0]    lerr_ff, lerr_in;
   logic [7:0]    op_ff, op_in;
   logic [PA_W-1:0] open_ff, open_in;

   // memory ports
   logic            pm_we;
   logic [PA_W-1:0] pm_wa, pm_ra;
   logic [7:0]      pm_wd, pm_rd;
   logic            mt_we;
   logic [PA_W-1:0] mt_wa, mt_wd, mt_ra, mt_rd;
   logic            bs_we;
   logic [NA_W-1:0] bs_wa, bs_ra;
   logic [PA_W-1:0] bs_wd, bs_rd;
   logic            tp_we;
   logic [TA_W-1:0] tp_wa;
   logic [7:0]      tp_wd, tp_rd;

   bf_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
      .clock, .wr_en(pm_we), .wr_addr(pm_wa), .wr_data(pm_wd),
      .rd_addr(pm_ra), .rd_data(pm_rd));
   bf_ram #(.WIDTH(PA_W), .DEPTH(PROG_DEPTH)) u_match (
      .clock, .wr_en(mt_we), .wr_addr(mt_wa), .wr_data(mt_wd),
      .rd_addr(mt_ra), .rd_data(mt_rd));
   bf_ram #(.WIDTH(PA_W), .DEPTH(NEST_DEPTH)) u_stack (
      .clock, .wr_en(bs_we), .wr_addr(bs_wa), .wr_data(bs_wd),
      .rd_addr(bs_ra), .rd_data(bs_rd));
   bf_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
      .clock, .wr_en(tp_we), .wr_addr(tp_wa), .wr_data(tp_wd),
      .rd_addr(tp_ff), .rd_data(tp_rd));

   logic accept, out_free;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // decode helpers
   logic [PL_W-1:0] pc_inc, pc_inc3;
   logic            fold_ok;
   assign pc_inc  = pc_ff + PL_W'(1);
   assign pc_inc3 = pc_ff + PL_W'(3);
   assign fold_ok = fold_ff && (pc_inc3 <= len_ff);

   // memory address / write control
   always_comb begin
      pm_we = accept && req_data.kind == KIND_LOAD && !len_ff[PA_W];
      pm_wa = len_ff[PA_W-1:0];
      pm_wd = req_data.program_char;
      pm_ra = pc_ff[PA_W-1:0];
      if (state_ff == S_FOLD1) pm_ra = pc_inc[PA_W-1:0];
      if (state_ff == S_FOLD2) pm_ra = PA_W'(pc_ff + PL_W'(2));
      mt_ra = pc_ff[PA_W-1:0];
      bs_ra = NA_W'(depth_ff - ND_W'(1));
      bs_we = accept && pm_we && req_data.program_char == CH_OPN
              && depth_ff < ND_W'(NEST_DEPTH);
      bs_wa = depth_ff[NA_W-1:0];
      bs_wd = len_ff[PA_W-1:0];
      mt_we = 1'b0;
      mt_wa = open_ff;
      mt_wd = PA_W'(len_ff - PL_W'(1));
      if (state_ff == S_LD_POP) begin
         mt_we = 1'b1;
         mt_wa = PA_W'(len_ff - PL_W'(1));
         mt_wd = bs_rd;
      end else if (state_ff == S_LD_MATCH) begin
         mt_we = 1'b1;
      end
      tp_we = 1'b0;
      tp_wa = tp_ff;
      tp_wd = 8'd0;
      if (state_ff == S_CLEAR) begin
         tp_we = 1'b1;
         tp_wa = clr_ff[TA_W-1:0];
      end else if (state_ff == S_CELL) begin
         case (op_ff)
            CH_INC:  begin tp_we = 1'b1; tp_wd = tp_rd + 8'd1; end
            CH_DEC:  begin tp_we = 1'b1; tp_wd = tp_rd - 8'd1; end
            CH_IN:   begin tp_we = item_ff.input_ready; tp_wd = item_ff.input_char; end
            default: tp_we = 1'b0;
         endcase
      end else if (state_ff == S_FOLD3) begin
         tp_we = (pm_rd == CH_CLS) && fold_ok && op_ff == CH_DEC;
      end
   end

   // main sequencer, next state
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      fold_in      = fold_ff;
      depth_in     = depth_ff;
      len_in       = len_ff;
      pc_in        = pc_ff;
      tp_in        = tp_ff;
      clr_in       = clr_ff;
      run_in       = run_ff;
      bfault_in    = bfault_ff;
      lerr_in      = lerr_ff;
      op_in        = op_ff;
      open_in      = open_ff;
      if (csr_valid && csr_ready) fold_in = csr_data;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_data;
               res_in = '{status: ST_OK, out_char: 8'd0, error_code: ERR_NONE,
                          program_counter: 13'(pc_ff)};
               state_in = S_REPLY;
               case (req_data.kind)
                  KIND_LOAD: begin
                     if (len_ff[PA_W]) begin
                        res_in.status = ST_ERR;
                        res_in.error_code = ERR_FULL;
                     end else begin
                        res_in.status = ST_LOADED;
                        len_in = len_ff + PL_W'(1);
                        run_in = RUN_IDLE;
                        if (req_data.program_char == CH_OPN) begin
                           if (depth_ff >= ND_W'(NEST_DEPTH)) bfault_in = 1'b1;
                           else depth_in = depth_ff + ND_W'(1);
                        end else if (req_data.program_char == CH_CLS) begin
                           if (depth_ff == '0) bfault_in = 1'b1;
                           else begin
                              depth_in = depth_ff - ND_W'(1);
                              state_in = S_LD_POP;
                           end
                        end
                     end
                  end
                  KIND_START: begin
                     pc_in = '0;
                     tp_in = '0;
                     clr_in = '0;
                     res_in.program_counter = '0;
                     state_in = S_CLEAR;
                     if (bfault_ff || depth_ff != '0) begin
                        run_in = RUN_ERR;
                        lerr_in = ERR_MATCH;
                        res_in.status = ST_ERR;
                        res_in.error_code = ERR_MATCH;
                     end else begin
                        run_in = RUN_GO;
                        lerr_in = ERR_NONE;
                     end
                  end
                  KIND_STEP: begin
                     if (run_ff == RUN_ERR) begin
                        res_in.status = ST_ERR;
                        res_in.error_code = lerr_ff;
                     end else if (run_ff != RUN_GO) begin
                        res_in.status = ST_HALT;
                     end else if (pc_ff >= len_ff) begin
                        run_in = RUN_HALT;
                        res_in.status = ST_HALT;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LD_POP: begin
            open_in = bs_rd;
            state_in = S_LD_MATCH;
         end
         S_LD_MATCH: state_in = S_REPLY;
         S_CLEAR: begin
            clr_in = clr_ff + (TA_W+1)'(1);
            if (clr_ff == (TA_W+1)'(TAPE_DEPTH - 1)) state_in = S_REPLY;
         end
         S_FETCH: state_in = S_DECODE;
         S_DECODE: begin
            op_in = pm_rd;
            state_in = S_CELL;
            case (pm_rd)
               CH_RT: begin
                  state_in = S_REPLY;
                  if (tp_ff == TA_W'(TAPE_DEPTH - 1)) begin
                     run_in = RUN_ERR; lerr_in = ERR_PAST;
                     res_in.status = ST_ERR; res_in.error_code = ERR_PAST;
                  end else begin
                     tp_in = tp_ff + TA_W'(1);
                     pc_in = pc_inc;
                     res_in.program_counter = 13'(pc_inc);
                  end
               end
               CH_LT: begin
                  state_in = S_REPLY;
                  if (tp_ff == '0) begin
                     run_in = RUN_ERR; lerr_in = ERR_BELOW;
                     res_in.status = ST_ERR; res_in.error_code = ERR_BELOW;
                  end else begin
                     tp_in = tp_ff - TA_W'(1);
                     pc_in = pc_inc;
                     res_in.program_counter = 13'(pc_inc);
                  end
               end
               CH_INC, CH_DEC, CH_OUT, CH_IN, CH_CLS: ;
               CH_OPN: if (fold_ok) state_in = S_FOLD1;
               default: begin
                  state_in = S_REPLY;
                  run_in = RUN_ERR; lerr_in = ERR_SYMBOL;
                  res_in.status = ST_ERR; res_in.error_code = ERR_SYMBOL;
               end
            endcase
         end
         S_FOLD1: state_in = S_FOLD2;
         S_FOLD2: begin
            op_in = pm_rd;
            state_in = S_FOLD3;
         end
         S_FOLD3: begin
            if (pm_rd == CH_CLS && op_ff == CH_DEC) begin
               pc_in = pc_inc3;
               res_in.program_counter = 13'(pc_inc3);
               state_in = S_REPLY;
            end else begin
               op_in = CH_OPN;
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            state_in = S_REPLY;
            pc_in = pc_inc;
            res_in.program_counter = 13'(pc_inc);
            case (op_ff)
               CH_OUT: begin
                  res_in.status = ST_OUT;
                  res_in.out_char = tp_rd;
               end
               CH_IN: if (!item_ff.input_ready) begin
                  pc_in = pc_ff;
                  res_in.program_counter = 13'(pc_ff);
                  res_in.status = ST_WAIT;
               end
               CH_OPN: if (tp_rd == 8'd0) state_in = S_MATCH;
               CH_CLS: if (tp_rd != 8'd0) state_in = S_MATCH;
               default: ;
            endcase
         end
         S_MATCH: begin
            pc_in = PL_W'(mt_rd) + PL_W'(1);
            res_in.program_counter = 13'(PL_W'(mt_rd) + PL_W'(1));
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) begin
               out_in = res_ff;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         fold_ff <= 1'b0;
         depth_ff <= '0;
         len_ff <= '0;
         pc_ff <= '0;
         tp_ff <= '0;
         clr_ff <= '0;
         run_ff <= RUN_IDLE;
         bfault_ff <= 1'b0;
         lerr_ff <= ERR_NONE;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         fold_ff <= fold_in;
         depth_ff <= depth_in;
         len_ff <= len_in;
         pc_ff <= pc_in;
         tp_ff <= tp_in;
         clr_ff <= clr_in;
         run_ff <= run_in;
         bfault_ff <= bfault_in;
         lerr_ff <= lerr_in;
      end
      item_ff <= item_in;
      res_ff <= res_in;
      out_ff <= out_in;
      op_ff <= op_in;
      open_ff <= open_in;
   end

   // checks
   `BF_ASSERT_IMP(a_len_bound, clock, reset, 1'b1, len_ff <= PL_W'(PROG_DEPTH), "length overflow")
   `BF_ASSERT_IMP(a_pc_bound, clock, reset, run_ff == RUN_GO, pc_ff <= len_ff, "pc past program")
   `BF_ASSERT_NEXT(a_one_beat, clock, reset, accept, !req_ready, "second item taken while busy")
endmodule
`default_nettype wire
